[rtl/mcr_pkg.sv]
// Package for the midpoint circle rasterizer.
// Holds register-map codes, the index of the last point of a step and the queue flag type.
// No dependencies.
`default_nettype none

package mcr_pkg;

    // Register file address width (three 32-bit registers at 0, 4, 8)
    localparam int ADDR_W = 4;

    // Register indexes, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_RADIUS   = 2'd2,
        REG_NONE     = 2'd3
    } t_reg_idx;

    // Index of the last point produced per step
    localparam logic [2:0] OCT_LAST = 3'd7;

    // Queue occupancy flags shared by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

`default_nettype wire

[rtl/mcr_front.sv]
// Front end of the circle rasterizer: takes step requests, keeps the
// midpoint iteration state and pushes one command per drawing step.
// Depends on mcr_pkg.
`default_nettype none

module mcr_front #(
    parameter int COORD_BITS = 12
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    input  wire                                  i_restart,
    output logic                                 o_stall,
    input  wire  [COORD_BITS-1:0]                i_center_x,
    input  wire  [COORD_BITS-1:0]                i_center_y,
    input  wire  [COORD_BITS-2:0]                i_radius,
    input  mcr_pkg::t_q_flags                    i_q_flags,
    output logic                                 o_push,
    output logic [4*COORD_BITS+1:0]              o_push_data
);
    import mcr_pkg::*;

    localparam int XW = COORD_BITS + 1;
    localparam int YW = COORD_BITS;
    localparam int EW = COORD_BITS + 3;

    logic signed [XW-1:0] r_step_x, n_step_x;
    logic        [YW-1:0] r_step_y, n_step_y;
    logic        [XW-1:0] r_x_inc, n_x_inc;
    logic        [XW-1:0] r_y_inc, n_y_inc;
    logic signed [EW-1:0] r_err, n_err;

    logic signed [XW-1:0] x_eff, x_upd;
    logic        [YW-1:0] y_eff, y_upd;
    logic        [XW-1:0] xi_eff, xi_upd;
    logic        [XW-1:0] yi_eff, yi_upd;
    logic signed [EW-1:0] e_eff, e_mid, e_upd, diam;
    logic                 accept;
    logic                 active;
    logic                 done;

    // Accept while the queue has room
    assign o_stall = i_q_flags.full;
    assign accept  = i_valid && !i_q_flags.full;

    // Apply restart ahead of the step
    always_comb begin
        diam = EW'({i_radius, 1'b0});
        if (i_restart) begin
            x_eff  = XW'({2'b00, i_radius}) - XW'(1);
            y_eff  = '0;
            xi_eff = XW'(1);
            yi_eff = XW'(1);
            e_eff  = EW'(1) - diam;
        end else begin
            x_eff  = r_step_x;
            y_eff  = r_step_y;
            xi_eff = r_x_inc;
            yi_eff = r_y_inc;
            e_eff  = r_err;
        end
    end

    // Draw only while x has not dropped below y
    assign active = $signed({x_eff[XW-1], x_eff}) >= $signed({2'b00, y_eff});

    // Midpoint update: y move first, then x move on the updated error
    always_comb begin
        y_upd  = y_eff;
        yi_upd = yi_eff;
        e_mid  = e_eff;
        if (e_eff <= 0) begin
            y_upd  = y_eff + YW'(1);
            e_mid  = e_eff + $signed(EW'(yi_eff));
            yi_upd = yi_eff + XW'(2);
        end
        x_upd  = x_eff;
        xi_upd = xi_eff;
        e_upd  = e_mid;
        if (e_mid > 0) begin
            x_upd  = x_eff - XW'(1);
            xi_upd = xi_eff + XW'(2);
            e_upd  = e_mid + $signed(EW'(xi_eff + XW'(2))) - diam;
        end
        done = $signed({x_upd[XW-1], x_upd}) < $signed({2'b00, y_upd});
    end

    // Next state on an accepted request: restart always takes effect, the step only when drawing
    always_comb begin
        n_step_x = r_step_x;
        n_step_y = r_step_y;
        n_x_inc  = r_x_inc;
        n_y_inc  = r_y_inc;
        n_err    = r_err;
        if (accept) begin
            n_step_x = active ? x_upd  : x_eff;
            n_step_y = active ? y_upd  : y_eff;
            n_x_inc  = active ? xi_upd : xi_eff;
            n_y_inc  = active ? yi_upd : yi_eff;
            n_err    = active ? e_upd  : e_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x <= '1;
            r_step_y <= '0;
            r_x_inc  <= XW'(1);
            r_y_inc  <= XW'(1);
            r_err    <= '0;
        end else begin
            r_step_x <= n_step_x;
            r_step_y <= n_step_y;
            r_x_inc  <= n_x_inc;
            r_y_inc  <= n_y_inc;
            r_err    <= n_err;
        end
    end

    // Push the snapshot of this step for the back end
    assign o_push      = accept && active;
    assign o_push_data = {i_center_x, i_center_y, x_eff, y_eff, done};

endmodule

`default_nettype wire

[rtl/mcr_queue.sv]
// Two-entry command queue between the rasterizer front and back ends.
// Depends on mcr_pkg.
`default_nettype none

module mcr_queue #(
    parameter int WIDTH = 50
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [WIDTH-1:0]  i_data,
    input  wire               i_pop,
    output logic [WIDTH-1:0]  o_data,
    output mcr_pkg::t_q_flags o_flags
);
    import mcr_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    // Store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_data        = r_mem[r_rd_ptr];
    assign o_flags.full  = r_count == 2'd2;
    assign o_flags.empty = r_count == 2'd0;

endmodule

`default_nettype wire

[rtl/mcr_back.sv]
// Back end of the circle rasterizer: walks the eight mirrored points of the
// queued step and holds each in the output register.
// Depends on mcr_pkg.
`default_nettype none

module mcr_back #(
    parameter int COORD_BITS = 12
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  [4*COORD_BITS+1:0]          i_cmd,
    input  mcr_pkg::t_q_flags                i_q_flags,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic signed [COORD_BITS+1:0]     o_point_x,
    output logic signed [COORD_BITS+1:0]     o_point_y,
    output logic [2:0]                       o_octant,
    output logic                             o_last,
    output logic                             o_finished
);
    import mcr_pkg::*;

    localparam int XW = COORD_BITS + 1;
    localparam int YW = COORD_BITS;
    localparam int PW = COORD_BITS + 2;

    logic [COORD_BITS-1:0] cx, cy;
    logic [XW-1:0]         sx;
    logic [YW-1:0]         sy;
    logic                  done;
    logic [PW-1:0]         cx_e, cy_e, x_e, y_e, a, b, px, py;
    logic                  load;

    logic [2:0]            r_oct;
    logic                  r_valid;
    logic signed [PW-1:0]  r_px, r_py;
    logic [2:0]            r_oct_out;
    logic                  r_last, r_fin;

    assign {cx, cy, sx, sy, done} = i_cmd;

    // Mirror the current (x, y) pair for this octant
    always_comb begin
        cx_e = PW'(cx);
        cy_e = PW'(cy);
        x_e  = {sx[XW-1], sx};
        y_e  = PW'(sy);
        a    = r_oct[2] ? y_e : x_e;
        b    = r_oct[2] ? x_e : y_e;
        px   = r_oct[1] ? cx_e - a : cx_e + a;
        py   = r_oct[0] ? cy_e + b : cy_e - b;
    end

    // Load a point when the output register is free or being drained
    assign load  = !i_q_flags.empty && (!r_valid || !i_stall);
    assign o_pop = load && (r_oct == OCT_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_oct <= r_oct + 3'd1;
            end
            r_valid <= load || (r_valid && i_stall);
        end
    end

    // Output payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px      <= $signed(px);
            r_py      <= $signed(py);
            r_oct_out <= r_oct;
            r_last    <= r_oct == OCT_LAST;
            r_fin     <= (r_oct == OCT_LAST) && done;
        end
    end

    assign o_valid    = r_valid;
    assign o_point_x  = r_px;
    assign o_point_y  = r_py;
    assign o_octant   = r_oct_out;
    assign o_last     = r_last;
    assign o_finished = r_fin;

endmodule

`default_nettype wire

[rtl/midpoint_circle_rasterizer.sv]
// Top level of the midpoint circle rasterizer: register file, front end,
// command queue and point back end. Depends on mcr_pkg, mcr_front,
// mcr_queue and mcr_back.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  step     | in        | i_valid / o_stall   | i_restart
//  point    | out       | o_valid / i_stall   | o_point_x/y, o_octant, o_last,
//           |           |                     | o_finished
//  config   | in        | psel/penable/pready | paddr, pwdata, prdata
//
// A step request is taken whenever the two-entry command queue has room.
// Each drawing step yields eight points, one per cycle through the output
// register while i_stall is low, so the single point port limits the step
// rate. A step with the circle complete gives no point. Reset (i_rst_n low,
// synchronous) clears the registers and the iteration state; no clearing
// pass follows. An output stall holds the current point; the front keeps
// taking steps until the queue fills.
`default_nettype none

module midpoint_circle_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // step requests
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire                              i_restart,
    // points
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic signed [COORD_BITS+1:0]     o_point_x,
    output logic signed [COORD_BITS+1:0]     o_point_y,
    output logic [2:0]                       o_octant,
    output logic                             o_last,
    output logic                             o_finished,
    // configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [mcr_pkg::ADDR_W-1:0]       paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import mcr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int QW = 4 * CB + 2;

    logic [CB-1:0] r_center_x;
    logic [CB-1:0] r_center_y;
    logic [CB-2:0] r_radius;
    t_reg_idx      reg_idx;
    logic          cfg_wr;

    t_q_flags      q_flags;
    logic          push, pop;
    logic [QW-1:0] push_data, head_data;

    // Register file
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_CENTER_X: r_center_x <= pwdata[CB-1:0];
                REG_CENTER_Y: r_center_y <= pwdata[CB-1:0];
                REG_RADIUS:   r_radius   <= pwdata[CB-2:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_CENTER_X: prdata = 32'(r_center_x);
            REG_CENTER_Y: prdata = 32'(r_center_y);
            REG_RADIUS:   prdata = 32'(r_radius);
            default:      prdata = '0;
        endcase
    end

    mcr_front #(
        .COORD_BITS(CB)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_restart   (i_restart),
        .o_stall     (o_stall),
        .i_center_x  (r_center_x),
        .i_center_y  (r_center_y),
        .i_radius    (r_radius),
        .i_q_flags   (q_flags),
        .o_push      (push),
        .o_push_data (push_data)
    );

    mcr_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_flags (q_flags)
    );

    mcr_back #(
        .COORD_BITS(CB)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_data),
        .i_q_flags  (q_flags),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y),
        .o_octant   (o_octant),
        .o_last     (o_last),
        .o_finished (o_finished)
    );

    // Finished only ever marks the closing point of a step
    a_fin_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_finished |-> o_last && o_octant == OCT_LAST)
        else $error("finished flag away from the last point");

    // The points of one step follow without gaps
    a_step_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid && o_octant == $past(o_octant) + 3'd1)
        else $error("gap or skip inside a step");

    // A queued step never gets lost: the queue never pushes while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_flags.full |-> !push)
        else $error("command pushed into a full queue");

endmodule

`default_nettype wire

[test/midpoint_circle_rasterizer_test.sv]
// Self-checking testbench for the midpoint circle rasterizer.
// Predicts the eight mirrored points of every drawing step and checks them in order.
// Depends on mcr_pkg and midpoint_circle_rasterizer.
`timescale 1ns / 100ps

module midpoint_circle_rasterizer_test;
    import mcr_pkg::*;

    localparam int PT_W          = 14;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 480;
    localparam int HALF_BUDGET   = 30;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic [2:0]             octant;
        logic                   last;
        logic                   finished;
    } t_circle_point;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_restart = 1'b0;
    logic i_stall = 1'b0;
    logic psel    = 1'b0;
    logic penable = 1'b0;
    logic pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;

    logic o_stall;
    logic o_valid;
    logic signed [PT_W-1:0] o_point_x;
    logic signed [PT_W-1:0] o_point_y;
    logic [2:0] o_octant;
    logic o_last;
    logic o_finished;
    logic [31:0] prdata;
    logic pready;

    // predictor copy of registers and iteration state
    logic [11:0]        cfg_cx = '0;
    logic [11:0]        cfg_cy = '0;
    logic [10:0]        cfg_radius = '0;
    logic signed [12:0] iter_x = -13'sd1;
    logic [11:0]        iter_y = '0;
    logic [12:0]        x_inc = 13'd1;
    logic [12:0]        y_inc = 13'd1;
    logic signed [14:0] err_term = '0;

    logic          pending_steps[$];
    t_circle_point expected_points[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int steps_accepted = 0;
    int points_checked = 0;
    int random_items = 0;
    int settings_used = 0;

    midpoint_circle_rasterizer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_restart  (i_restart),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y),
        .o_octant   (o_octant),
        .o_last     (o_last),
        .o_finished (o_finished),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 i_clk = ~i_clk;

    // Advance the circle by one step and queue the points it plots.
    function automatic void plot_step(input logic restart);
        int cx, cy, x, y, diam;
        int px[8];
        int py[8];
        logic done;
        t_circle_point pt;
        if (restart) begin
            iter_x   = 13'(int'(cfg_radius) - 1);
            iter_y   = '0;
            x_inc    = 13'd1;
            y_inc    = 13'd1;
            err_term = 15'(1 - 2 * int'(cfg_radius));
        end
        x = int'(iter_x);
        y = int'(iter_y);
        if (x < y)
            return;
        cx = int'(cfg_cx);
        cy = int'(cfg_cy);
        px[0] = cx + x; py[0] = cy - y;
        px[1] = cx + x; py[1] = cy + y;
        px[2] = cx - x; py[2] = cy - y;
        px[3] = cx - x; py[3] = cy + y;
        px[4] = cx + y; py[4] = cy - x;
        px[5] = cx + y; py[5] = cy + x;
        px[6] = cx - y; py[6] = cy - x;
        px[7] = cx - y; py[7] = cy + x;
        diam = 2 * int'(cfg_radius);
        // move up while the error term allows, then step inward if it overshoots
        if (err_term <= 0) begin
            iter_y   = iter_y + 12'd1;
            err_term = 15'(int'(err_term) + int'(y_inc));
            y_inc    = y_inc + 13'd2;
        end
        if (err_term > 0) begin
            iter_x   = iter_x - 13'sd1;
            x_inc    = x_inc + 13'd2;
            err_term = 15'(int'(err_term) + int'(x_inc) - diam);
        end
        done = int'(iter_x) < int'(iter_y);
        for (int k = 0; k < 8; k++) begin
            pt.x        = PT_W'(px[k]);
            pt.y        = PT_W'(py[k]);
            pt.octant   = 3'(k);
            pt.last     = (3'(k) == OCT_LAST);
            pt.finished = (3'(k) == OCT_LAST) && done;
            expected_points.push_back(pt);
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%t mismatch: %s", $realtime, msg);
    endfunction

    // Driver: predict taken items, offer the next one when the slot is free.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                plot_step(i_restart);
                steps_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_steps.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    i_valid   <= 1'b1;
                    i_restart <= pending_steps.pop_front();
                end else begin
                    i_valid   <= 1'b0;
                    i_restart <= 1'($urandom_range(1));
                end
            end
        end
    end

    // Monitor: check each taken point against the oldest prediction.
    always @(posedge i_clk) begin
        t_circle_point want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                points_checked++;
                if (expected_points.size() == 0) begin
                    note_failure($sformatf("unexpected point x=%0d y=%0d oct=%0d",
                                           o_point_x, o_point_y, o_octant));
                end else begin
                    want = expected_points.pop_front();
                    if (o_point_x !== want.x || o_point_y !== want.y ||
                        o_octant !== want.octant || o_last !== want.last ||
                        o_finished !== want.finished)
                        note_failure($sformatf(
                            {"exp x=%0d y=%0d oct=%0d last=%0b fin=%0b, ",
                             "got x=%0d y=%0d oct=%0d last=%0b fin=%0b"},
                            want.x, want.y, want.octant, want.last, want.finished,
                            o_point_x, o_point_y, o_octant, o_last, o_finished));
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Write one register through the setup and access phases.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER_X: cfg_cx = value[11:0];
            REG_CENTER_Y: cfg_cy = value[11:0];
            REG_RADIUS:   cfg_radius = value[10:0];
            default: ;
        endcase
    endtask

    task automatic set_circle(input int cx, input int cy, input int r);
        write_reg(REG_RADIUS, 32'(r));
        write_reg(REG_CENTER_X, 32'(cx));
        write_reg(REG_CENTER_Y, 32'(cy));
        settings_used++;
    endtask

    // Hold until every item is taken and every point has come back.
    task automatic drain();
        while (pending_steps.size() != 0 || i_valid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Queue whole circles, cut-short circles and lone noise items.
    task automatic queue_circles(input int budget);
        int n, len, extra;
        n = 0;
        while (n < budget) begin
            if ($urandom_range(9) == 0) begin
                pending_steps.push_back(1'($urandom_range(1)));
                n++;
            end else begin
                len = (int'(cfg_radius) * 707) / 1000 + 1;
                if (len > 40)
                    len = 40;
                if ($urandom_range(4) == 0)
                    len = $urandom_range(1, len);
                pending_steps.push_back(1'b1);
                for (int k = 1; k < len; k++)
                    pending_steps.push_back(1'b0);
                n += len;
                // extra non-restart steps follow; past completion they plot nothing
                extra = $urandom_range(2);
                repeat (extra) pending_steps.push_back(1'b0);
                n += extra;
            end
        end
        random_items += n;
    endtask

    function automatic int pick_coord();
        case ($urandom_range(5))
            0: return 0;
            1: return 4095;
            default: return $urandom_range(4095);
        endcase
    endfunction

    initial begin
        int phase, r;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset and with zero radius nothing is plotted
        pending_steps = '{1'b0, 1'b0, 1'b1, 1'b0};
        drain();

        // largest radius at the far corner, restart in mid-circle,
        // write to the unused address must be ignored
        set_circle(4095, 0, 2047);
        write_reg(REG_NONE, 32'h0000_0abc);
        pending_steps = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
        drain();

        // radius one: a single step finishes, then steps are dropped
        set_circle(0, 4095, 1);
        pending_steps = '{1'b1, 1'b0, 1'b1, 1'b0};
        drain();

        // radius two: x meets y, duplicates emitted
        set_circle(2048, 2047, 2);
        pending_steps = '{1'b1, 1'b0, 1'b0, 1'b0};
        drain();

        // random settings, cycling through the idle patterns
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 82; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 82; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            if (phase == 3)
                r = 2047;
            else if ($urandom_range(3) == 0)
                r = $urandom_range(2047);
            else
                r = $urandom_range(48);
            set_circle(pick_coord(), pick_coord(), r);
            queue_circles(HALF_BUDGET);
            drain();
            queue_circles(HALF_BUDGET);
            drain();
            phase++;
        end

        if (expected_points.size() != 0)
            note_failure($sformatf("%0d points never arrived", expected_points.size()));
        $display("Covered %0d steps and %0d points over %0d circle settings,",
                 steps_accepted, points_checked, settings_used);
        $display("radius 0..2047, centers at both corners, four idle/stall patterns.");
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d failures", mismatch_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("timeout with %0d points outstanding", expected_points.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/mcr_pkg.sv
rtl/mcr_front.sv
rtl/mcr_queue.sv
rtl/mcr_back.sv
rtl/midpoint_circle_rasterizer.sv
test/midpoint_circle_rasterizer_test.sv
